>>> design/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
package bpa_pkg;

    localparam int FRAME_BITS  = 20;
    localparam int TOP_ORDER   = 10;
    localparam int STACK_DEPTH = 256;
    localparam int NORD        = TOP_ORDER + 1;
    localparam int ORD_W       = $clog2(NORD);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PAGE_W      = 21;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;
    localparam int LOG_W       = 5;
    localparam int MEM_DEPTH   = NORD * STACK_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SPAN  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOMEM   = 3'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

    localparam logic [ORD_W-1:0] ORD_LIMIT_RESET = ORD_W'(TOP_ORDER);

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_ALLOC_SETUP, CMD_POP, CMD_POP_DATA, CMD_SPLIT,
        CMD_FREE_SETUP, CMD_SRCH_START, CMD_SRCH_RD, CMD_MERGE, CMD_FREE_COMMIT,
        CMD_RM_RD, CMD_RM_WR, CMD_RM_NEXT, CMD_PUSH_FINAL, CMD_SPAN_SETUP,
        CMD_SPAN_CALC, CMD_SPAN_PUSH, CMD_OUT
    } cmd_t;

    typedef struct packed {
        cmd_t            op;
        logic            st_load;
        logic [ST_W-1:0] st_code;
    } cmd_pkt_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            req_zero;
        logic            frame_zero;
        logic            ord_over;
        logic            misalign;
        logic            no_src;
        logic            split_full;
        logic            lvl_above;
        logic            lvl_below_mx;
        logic            idx_zero;
        logic            match;
        logic            rm_more;
        logic            lvl_at_top;
        logic            lvl_full;
        logic            curr_lt_end;
    } sts_t;

    // Index of the highest set bit, zero for zero.
    function automatic logic [LOG_W-1:0] floor_log2(input logic [PAGE_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < PAGE_W; i++) begin
            if (v[i]) r = LOG_W'(i);
        end
        return r;
    endfunction

    // Index of the lowest set bit.
    function automatic logic [LOG_W-1:0] ctz(input logic [PAGE_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = PAGE_W - 1; i >= 0; i--) begin
            if (v[i]) r = LOG_W'(i);
        end
        return r;
    endfunction

    // Smallest order whose block holds n pages.
    function automatic logic [LOG_W-1:0] ceil_ord(input logic [PAGE_W-1:0] n);
        logic [PAGE_W-1:0] m;
        m = n - PAGE_W'(1);
        if (n <= PAGE_W'(1)) return '0;
        return floor_log2(m) + LOG_W'(1);
    endfunction

    // Stack memory address of one entry of one order.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [ORD_W-1:0] ord,
                                                   input logic [IDX_W-1:0] idx);
        return ADDR_W'(ord) * ADDR_W'(STACK_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

>>> design/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/bpa_ctrl.sv
// Sequencing state machine of the buddy page allocator.
module bpa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  bpa_pkg::sts_t   sts,
    output bpa_pkg::cmd_pkt_t cmd
);
    import bpa_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_SETUP     = 14'b00000000000010,
        S_POP_RD    = 14'b00000000000100,
        S_POP_DATA  = 14'b00000000001000,
        S_SPLIT     = 14'b00000000010000,
        S_SRCH_CHK  = 14'b00000000100000,
        S_SRCH_RD   = 14'b00000001000000,
        S_SRCH_CMP  = 14'b00000010000000,
        S_FREE_FULL = 14'b00000100000000,
        S_RM        = 14'b00001000000000,
        S_RM_WR     = 14'b00010000000000,
        S_SPAN_CALC = 14'b00100000000000,
        S_SPAN_PUSH = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath command.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = CMD_NONE;
        cmd.st_load    = 1'b0;
        cmd.st_code    = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next  = S_DONE;
                cmd.st_load = 1'b1;
                cmd.st_code = ST_IGNORED;
                if (sts.op == OP_ALLOC)
                begin
                    if (sts.req_zero)
                    begin
                        cmd.st_code = ST_IGNORED;
                    end
                    else if (sts.ord_over || sts.no_src)
                    begin
                        cmd.st_code = ST_NOMEM;
                    end
                    else if (sts.split_full)
                    begin
                        cmd.st_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.st_load = 1'b0;
                        cmd.op      = CMD_ALLOC_SETUP;
                        state_next  = S_POP_RD;
                    end
                end
                else if (sts.op == OP_FREE)
                begin
                    if (sts.frame_zero || sts.req_zero)
                    begin
                        cmd.st_code = ST_IGNORED;
                    end
                    else if (sts.ord_over || sts.misalign)
                    begin
                        cmd.st_code = ST_BADFREE;
                    end
                    else
                    begin
                        cmd.st_load = 1'b0;
                        cmd.op      = CMD_FREE_SETUP;
                        state_next  = S_SRCH_CHK;
                    end
                end
                else if (sts.op == OP_SPAN)
                begin
                    if (!sts.req_zero)
                    begin
                        cmd.st_load = 1'b0;
                        cmd.op      = CMD_SPAN_SETUP;
                        state_next  = S_SPAN_CALC;
                    end
                end
            end
            S_POP_RD:
            begin
                cmd.op     = CMD_POP;
                state_next = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                cmd.op     = CMD_POP_DATA;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (sts.lvl_above)
                begin
                    cmd.op = CMD_SPLIT;
                end
                else
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_SRCH_CHK:
            begin
                if (sts.lvl_below_mx)
                begin
                    cmd.op     = CMD_SRCH_START;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_FREE_FULL;
                end
            end
            S_SRCH_RD:
            begin
                if (sts.idx_zero)
                begin
                    state_next = S_FREE_FULL;
                end
                else
                begin
                    cmd.op     = CMD_SRCH_RD;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.match)
                begin
                    cmd.op     = CMD_MERGE;
                    state_next = S_SRCH_CHK;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_FREE_FULL:
            begin
                if (sts.lvl_full)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_FREE_COMMIT;
                    state_next = S_RM;
                end
            end
            S_RM:
            begin
                if (sts.lvl_at_top)
                begin
                    cmd.op      = CMD_PUSH_FINAL;
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_DONE;
                end
                else if (sts.rm_more)
                begin
                    cmd.op     = CMD_RM_RD;
                    state_next = S_RM_WR;
                end
                else
                begin
                    cmd.op = CMD_RM_NEXT;
                end
            end
            S_RM_WR:
            begin
                cmd.op     = CMD_RM_WR;
                state_next = S_RM;
            end
            S_SPAN_CALC:
            begin
                if (sts.curr_lt_end)
                begin
                    cmd.op     = CMD_SPAN_CALC;
                    state_next = S_SPAN_PUSH;
                end
                else
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_SPAN_PUSH:
            begin
                if (sts.lvl_full)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_SPAN_PUSH;
                    state_next = S_SPAN_CALC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/bpa_dp.sv
// Datapath of the buddy page allocator: stack counts, totals and the stack memory.
module bpa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::cmd_pkt_t             cmd,
    output bpa_pkg::sts_t                 sts,
    input  logic [bpa_pkg::OP_W-1:0]      in_op,
    input  logic [bpa_pkg::FRAME_BITS-1:0] in_frame,
    input  logic [bpa_pkg::PAGE_W-1:0]    in_count,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::ORD_W-1:0]     cfg_data,
    output logic [bpa_pkg::FRAME_BITS-1:0] alloc_frame,
    output logic [bpa_pkg::ST_W-1:0]      status,
    output logic [bpa_pkg::PAGE_W-1:0]    free_pages,
    output logic [bpa_pkg::PAGE_W-1:0]    managed_pages
);
    import bpa_pkg::*;

    // Control state, initialised by reset.
    logic [CNT_W-1:0]  cnt_reg [NORD];
    logic [CNT_W-1:0]  cnt_next [NORD];
    logic [ORD_W-1:0]  ord_limit_reg, ord_limit_next;
    logic [PAGE_W-1:0] free_reg, free_next;
    logic [PAGE_W-1:0] man_reg, man_next;

    // Working registers of one transaction.
    logic [OP_W-1:0]       op_reg, op_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [PAGE_W-1:0]     n_reg, n_next;
    logic [ORD_W-1:0]      req_reg, req_next;
    logic [ORD_W-1:0]      lvl_reg, lvl_next;
    logic [ORD_W-1:0]      top_reg, top_next;
    logic [PAGE_W-1:0]     addr_reg, addr_next;
    logic [PAGE_W-1:0]     end_reg, end_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pos_reg [NORD];
    logic [IDX_W-1:0]      pos_next [NORD];
    logic [ST_W-1:0]       status_reg, status_next;
    logic [FRAME_BITS-1:0] out_frame_reg, out_frame_next;
    logic [ST_W-1:0]       out_status_reg, out_status_next;
    logic [PAGE_W-1:0]     out_free_reg, out_free_next;
    logic [PAGE_W-1:0]     out_man_reg, out_man_next;

    // Memory port signals.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [FRAME_BITS-1:0] ram_wdata, ram_rdata;

    // Derived values.
    logic [ORD_W-1:0]      mx;
    logic [LOG_W-1:0]      req_ceil;
    logic [ORD_W-1:0]      src_ord;
    logic                  src_found;
    logic                  split_full;
    logic [PAGE_W-1:0]     low_mask;
    logic [ORD_W-1:0]      lo, lvl_inc;
    logic [CNT_W-1:0]      cnt_lvl, cnt_lo, cnt_top, cnt_dec, idx_dec, idx_inc;
    logic [PAGE_W-1:0]     lvl_pg, lo_pg, top_pg;
    logic [PAGE_W-1:0]     buddy;
    logic [PAGE_W-1:0]     span_rem;
    logic [PAGE_W:0]       span_sum;
    logic [LOG_W-1:0]      span_so, span_ao, span_o;

    assign mx       = (ord_limit_reg > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : ord_limit_reg;
    assign req_ceil = ceil_ord(n_reg);
    assign low_mask = (PAGE_W'(1) << req_ceil) - PAGE_W'(1);
    assign lo       = lvl_reg - ORD_W'(1);
    assign lvl_inc  = lvl_reg + ORD_W'(1);
    assign cnt_lvl  = cnt_reg[lvl_reg];
    assign cnt_lo   = cnt_reg[lo];
    assign cnt_top  = cnt_reg[top_reg];
    assign cnt_dec  = cnt_lvl - CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign lvl_pg   = PAGE_W'(1) << lvl_reg;
    assign lo_pg    = PAGE_W'(1) << lo;
    assign top_pg   = PAGE_W'(1) << top_reg;
    assign buddy    = addr_reg ^ lvl_pg;
    assign span_sum = {1'b0, PAGE_W'(frame_reg)} + {1'b0, n_reg};
    assign span_rem = end_reg - addr_reg;
    assign span_so  = floor_log2(span_rem);
    assign span_ao  = (addr_reg == '0) ? LOG_W'(mx) : ctz(addr_reg);

    // Span block order: alignment, remaining length and max order.
    always_comb
    begin
        span_o = span_ao;
        if (span_so < span_o)
        begin
            span_o = span_so;
        end
        if (LOG_W'(mx) < span_o)
        begin
            span_o = LOG_W'(mx);
        end
    end

    // Alloc source order and split room check.
    always_comb
    begin
        src_ord    = '0;
        src_found  = 1'b0;
        split_full = 1'b0;
        for (int q = TOP_ORDER; q >= 0; q--)
        begin
            if (LOG_W'(q) >= req_ceil && ORD_W'(q) <= mx && cnt_reg[q] != '0)
            begin
                src_ord   = ORD_W'(q);
                src_found = 1'b1;
            end
        end
        for (int q = 0; q <= TOP_ORDER; q++)
        begin
            if (LOG_W'(q) >= req_ceil && ORD_W'(q) < src_ord
                && cnt_reg[q] >= CNT_W'(STACK_DEPTH))
            begin
                split_full = 1'b1;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.op           = op_reg;
        sts.req_zero     = (n_reg == '0);
        sts.frame_zero   = (frame_reg == '0);
        sts.ord_over     = (req_ceil > LOG_W'(mx));
        sts.misalign     = ((PAGE_W'(frame_reg) & low_mask) != '0);
        sts.no_src       = !src_found;
        sts.split_full   = split_full;
        sts.lvl_above    = (lvl_reg > req_reg);
        sts.lvl_below_mx = (lvl_reg < mx);
        sts.idx_zero     = (idx_reg == '0);
        sts.match        = (ram_rdata == buddy[FRAME_BITS-1:0]);
        sts.rm_more      = (idx_inc < cnt_lvl);
        sts.lvl_at_top   = (lvl_reg == top_reg);
        sts.lvl_full     = (cnt_lvl >= CNT_W'(STACK_DEPTH));
        sts.curr_lt_end  = (addr_reg < end_reg);
    end

    // Register updates and memory accesses per command.
    always_comb
    begin
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        ord_limit_next  = ord_limit_reg;
        free_next       = free_reg;
        man_next        = man_reg;
        op_next         = op_reg;
        frame_next      = frame_reg;
        n_next          = n_reg;
        req_next        = req_reg;
        lvl_next        = lvl_reg;
        top_next        = top_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        out_frame_next  = out_frame_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_man_next    = out_man_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        if (cfg_we)
        begin
            ord_limit_next = cfg_data;
        end
        if (cmd.st_load)
        begin
            status_next = cmd.st_code;
        end
        case (cmd.op)
            CMD_LOAD:
            begin
                op_next    = in_op;
                frame_next = in_frame;
                n_next     = in_count;
            end
            CMD_ALLOC_SETUP:
            begin
                req_next = ORD_W'(req_ceil);
                lvl_next = src_ord;
            end
            CMD_POP:
            begin
                cnt_next[lvl_reg] = cnt_dec;
                free_next         = free_reg - lvl_pg;
                ram_raddr         = mem_addr(lvl_reg, cnt_dec[IDX_W-1:0]);
            end
            CMD_POP_DATA:
            begin
                addr_next = PAGE_W'(ram_rdata);
            end
            CMD_SPLIT:
            begin
                ram_we       = 1'b1;
                ram_waddr    = mem_addr(lo, cnt_lo[IDX_W-1:0]);
                ram_wdata    = FRAME_BITS'(addr_reg + lo_pg);
                cnt_next[lo] = cnt_lo + CNT_W'(1);
                free_next    = free_reg + lo_pg;
                lvl_next     = lo;
            end
            CMD_FREE_SETUP:
            begin
                req_next  = ORD_W'(req_ceil);
                lvl_next  = ORD_W'(req_ceil);
                addr_next = PAGE_W'(frame_reg);
            end
            CMD_SRCH_START:
            begin
                idx_next = cnt_lvl;
            end
            CMD_SRCH_RD:
            begin
                idx_next  = idx_dec;
                ram_raddr = mem_addr(lvl_reg, idx_dec[IDX_W-1:0]);
            end
            CMD_MERGE:
            begin
                pos_next[lvl_reg] = idx_reg[IDX_W-1:0];
                addr_next         = addr_reg & ~lvl_pg;
                lvl_next          = lvl_inc;
            end
            CMD_FREE_COMMIT:
            begin
                top_next = lvl_reg;
                lvl_next = req_reg;
                idx_next = CNT_W'(pos_reg[req_reg]);
            end
            CMD_RM_RD:
            begin
                ram_raddr = mem_addr(lvl_reg, idx_inc[IDX_W-1:0]);
            end
            CMD_RM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = mem_addr(lvl_reg, idx_reg[IDX_W-1:0]);
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
            end
            CMD_RM_NEXT:
            begin
                cnt_next[lvl_reg] = cnt_dec;
                free_next         = free_reg - lvl_pg;
                lvl_next          = lvl_inc;
                if (lvl_inc <= ORD_W'(TOP_ORDER))
                begin
                    idx_next = CNT_W'(pos_reg[lvl_inc]);
                end
            end
            CMD_PUSH_FINAL:
            begin
                ram_we            = 1'b1;
                ram_waddr         = mem_addr(top_reg, cnt_top[IDX_W-1:0]);
                ram_wdata         = addr_reg[FRAME_BITS-1:0];
                cnt_next[top_reg] = cnt_top + CNT_W'(1);
                free_next         = free_reg + top_pg;
            end
            CMD_SPAN_SETUP:
            begin
                addr_next = PAGE_W'(frame_reg);
                if (span_sum > (PAGE_W + 1)'(1 << FRAME_BITS))
                begin
                    end_next = PAGE_W'(1 << FRAME_BITS);
                end
                else
                begin
                    end_next = span_sum[PAGE_W-1:0];
                end
            end
            CMD_SPAN_CALC:
            begin
                lvl_next = ORD_W'(span_o);
            end
            CMD_SPAN_PUSH:
            begin
                ram_we            = 1'b1;
                ram_waddr         = mem_addr(lvl_reg, cnt_lvl[IDX_W-1:0]);
                ram_wdata         = addr_reg[FRAME_BITS-1:0];
                cnt_next[lvl_reg] = cnt_lvl + CNT_W'(1);
                free_next         = free_reg + lvl_pg;
                man_next          = man_reg + lvl_pg;
                addr_next         = addr_reg + lvl_pg;
            end
            CMD_OUT:
            begin
                out_status_next = status_reg;
                out_free_next   = free_reg;
                out_man_next    = man_reg;
                if (op_reg == OP_ALLOC && status_reg == ST_OK)
                begin
                    out_frame_next = addr_reg[FRAME_BITS-1:0];
                end
                else
                begin
                    out_frame_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Counts, totals and the order limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NORD; q++)
            begin
                cnt_reg[q] <= '0;
            end
            ord_limit_reg <= ORD_LIMIT_RESET;
            free_reg      <= '0;
            man_reg       <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ord_limit_reg <= ord_limit_next;
            free_reg      <= free_next;
            man_reg       <= man_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        frame_reg      <= frame_next;
        n_reg          <= n_next;
        req_reg        <= req_next;
        lvl_reg        <= lvl_next;
        top_reg        <= top_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        out_man_reg    <= out_man_next;
    end

    // Free block stacks of all orders.
    bpa_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign alloc_frame   = out_frame_reg;
    assign status        = out_status_reg;
    assign free_pages    = out_free_reg;
    assign managed_pages = out_man_reg;

endmodule

>>> design/buddy_page_allocator.sv
// Buddy page allocator: one transaction in, one result out, one at a time.
// An ignored or rejected request goes straight to the result; an alloc pops its source block and
// splits it down to the requested order; a free probes its stack for each buddy, merges order by
// order and shifts entries on removal; add span seeds one aligned block at a time.
// A new transaction can be accepted in the same cycle as the result is presented; a held result stalls the next result.
// Reset clears the stack counts and totals and sets the order limit to 10; memory is not cleared.
module buddy_page_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bpa_pkg::OP_W-1:0]       op,
    input  logic [bpa_pkg::FRAME_BITS-1:0] frame,
    input  logic [bpa_pkg::PAGE_W-1:0]     count_pages,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bpa_pkg::FRAME_BITS-1:0] alloc_frame,
    output logic [bpa_pkg::ST_W-1:0]       status,
    output logic [bpa_pkg::PAGE_W-1:0]     free_pages,
    output logic [bpa_pkg::PAGE_W-1:0]     managed_pages,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpa_pkg::ORD_W-1:0]      cfg_data
);
    import bpa_pkg::*;

    cmd_pkt_t cmd;
    sts_t     sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath and stack memory.
    bpa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (op),
        .in_frame      (frame),
        .in_count      (count_pages),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .alloc_frame   (alloc_frame),
        .status        (status),
        .free_pages    (free_pages),
        .managed_pages (managed_pages)
    );

    // Only one transaction is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while busy");

    // A failed or ignored request never reports a frame.
    a_frame_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> alloc_frame == '0)
        else $error("frame reported with non-ok status");

    // A result appears only after the sequencer has been busy.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a transaction");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the buddy page allocator with a built-in free-stack predictor.
`timescale 1ns / 100ps

module tb;
    import bpa_pkg::*;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [FRAME_BITS-1:0] frame;
        logic [PAGE_W-1:0]     count;
    } request_t;

    typedef struct {
        logic [FRAME_BITS-1:0] alloc_frame;
        logic [ST_W-1:0]       status;
        logic [PAGE_W-1:0]     free_pages;
        logic [PAGE_W-1:0]     managed_pages;
    } outcome_t;

    typedef struct {
        logic [FRAME_BITS-1:0] frame;
        int                    ord;
    } block_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int LONG_STALL     = 3000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       op;
    logic [FRAME_BITS-1:0] frame;
    logic [PAGE_W-1:0]     count_pages;
    logic                  out_valid;
    logic                  out_ready;
    logic [FRAME_BITS-1:0] alloc_frame;
    logic [ST_W-1:0]       status;
    logic [PAGE_W-1:0]     free_pages;
    logic [PAGE_W-1:0]     managed_pages;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ORD_W-1:0]      cfg_data;

    // Predictor state: free stacks per order, totals and the order limit.
    logic [FRAME_BITS-1:0] order_stack[NORD][$];
    logic [PAGE_W-1:0]     free_total;
    logic [PAGE_W-1:0]     managed_total;
    int                    max_ord;

    request_t pending_requests[$];
    outcome_t expected_results[$];
    block_t   live_blocks[$];
    int       mismatches;
    int       results_seen;

    buddy_page_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .frame         (frame),
        .count_pages   (count_pages),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .alloc_frame   (alloc_frame),
        .status        (status),
        .free_pages    (free_pages),
        .managed_pages (managed_pages),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Smallest order whose block holds n pages.
    function automatic int order_for(longint unsigned n);
        int o = 0;
        while (o < 63 && (64'd1 << o) < n) o++;
        return o;
    endfunction

    function automatic int limit_order();
        return (max_ord > TOP_ORDER) ? TOP_ORDER : max_ord;
    endfunction

    function automatic void stack_push(int o, longint unsigned f);
        order_stack[o].push_back(f[FRAME_BITS-1:0]);
        free_total = free_total + PAGE_W'(64'd1 << o);
    endfunction

    // Work out the result of one request and update the predicted free stacks.
    function automatic outcome_t allocator_predict(request_t rq);
        outcome_t        res;
        int              mx;
        int              o;
        int              i;
        int              k;
        int              p;
        int              so;
        int              ao;
        int              pos[NORD];
        bit              full;
        longint unsigned blk;
        longint unsigned addr;
        longint unsigned bud;
        longint unsigned curr;
        longint unsigned stop;
        mx = limit_order();
        res.alloc_frame = '0;
        res.status = ST_IGNORED;
        if (rq.op == OP_ALLOC && rq.count != 0) begin
            o = order_for(rq.count);
            i = o;
            while (i <= mx && order_stack[i].size() == 0) i++;
            if (o > mx || i > mx) begin
                res.status = ST_NOMEM;
            end
            else begin
                full = 1'b0;
                for (int j = o; j < i; j++)
                    if (order_stack[j].size() >= STACK_DEPTH) full = 1'b1;
                if (full) begin
                    res.status = ST_FULL;
                end
                else begin
                    blk = order_stack[i].pop_back();
                    free_total = free_total - PAGE_W'(64'd1 << i);
                    while (i > o) begin
                        i--;
                        stack_push(i, blk + (64'd1 << i));
                    end
                    res.alloc_frame = blk[FRAME_BITS-1:0];
                    res.status = ST_OK;
                end
            end
        end
        else if (rq.op == OP_FREE && rq.frame != 0 && rq.count != 0) begin
            o = order_for(rq.count);
            if (o > mx || (rq.frame & ((64'd1 << o) - 1)) != 0) begin
                res.status = ST_BADFREE;
            end
            else begin
                // Merge upward while the buddy sits on its stack, searching from the top.
                addr = rq.frame;
                k = o;
                while (k < mx) begin
                    bud = addr ^ (64'd1 << k);
                    p = -1;
                    for (int q = order_stack[k].size() - 1; q >= 0; q--) begin
                        if (order_stack[k][q] == bud[FRAME_BITS-1:0]) begin
                            p = q;
                            break;
                        end
                    end
                    if (p < 0) break;
                    pos[k] = p;
                    if (bud < addr) addr = bud;
                    k++;
                end
                if (order_stack[k].size() >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end
                else begin
                    for (int j = o; j < k; j++) begin
                        order_stack[j].delete(pos[j]);
                        free_total = free_total - PAGE_W'(64'd1 << j);
                    end
                    stack_push(k, addr);
                    res.status = ST_OK;
                end
            end
        end
        else if (rq.op == OP_SPAN && rq.count != 0) begin
            // Seed the span as maximal aligned blocks, cut at the end of frame space.
            curr = rq.frame;
            stop = curr + rq.count;
            if (stop > (64'd1 << FRAME_BITS)) stop = 64'd1 << FRAME_BITS;
            res.status = ST_OK;
            while (curr < stop) begin
                so = 0;
                while (so < 63 && ((stop - curr) >> (so + 1)) != 0) so++;
                ao = 0;
                if (curr == 0) ao = mx;
                else while (ao < 63 && curr[ao] == 1'b0) ao++;
                o = ao;
                if (o > so) o = so;
                if (o > mx) o = mx;
                if (order_stack[o].size() >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                    break;
                end
                stack_push(o, curr);
                managed_total = managed_total + PAGE_W'(64'd1 << o);
                curr += 64'd1 << o;
            end
        end
        res.free_pages = free_total;
        res.managed_pages = managed_total;
        return res;
    endfunction

    // Queue one request together with its predicted result.
    function automatic void issue(logic [OP_W-1:0] o, logic [FRAME_BITS-1:0] f,
                                  logic [PAGE_W-1:0] n);
        request_t rq;
        outcome_t res;
        rq.op = o;
        rq.frame = f;
        rq.count = n;
        res = allocator_predict(rq);
        if (o == OP_ALLOC && res.status == ST_OK)
            live_blocks.push_back('{res.alloc_frame, order_for(n)});
        pending_requests.push_back(rq);
        expected_results.push_back(res);
    endfunction

    // Free one block that is currently allocated, sometimes naming fewer pages.
    function automatic void free_live_block();
        int     idx;
        block_t b;
        idx = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[idx];
        live_blocks.delete(idx);
        if (b.ord == 0)
            issue(OP_FREE, b.frame, PAGE_W'(1));
        else
            issue(OP_FREE, b.frame,
                  PAGE_W'($urandom_range((1 << (b.ord - 1)) + 1, 1 << b.ord)));
    endfunction

    function automatic void random_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10 || managed_total == 0 && sel < 60) begin
            if (free_total < 8192)
                issue(OP_SPAN, FRAME_BITS'($urandom_range(0, 8191)),
                      PAGE_W'($urandom_range(1, 2048)));
            else
                issue(OP_ALLOC, FRAME_BITS'($urandom_range(1, 16)), '0);
        end
        else if (sel < 50) begin
            issue(OP_ALLOC, FRAME_BITS'($urandom()),
                  PAGE_W'($urandom_range(1, 1 << $urandom_range(0, limit_order()))));
        end
        else if (sel < 88 && live_blocks.size() != 0) begin
            free_live_block();
        end
        else if (sel < 94) begin
            // Misaligned or oversized frees near the seeded region.
            issue(OP_FREE, FRAME_BITS'($urandom_range(1, 8191)),
                  PAGE_W'($urandom_range(0, 2048)));
        end
        else begin
            issue(OP_W'($urandom_range(0, 3)), FRAME_BITS'($urandom()),
                  PAGE_W'($urandom_range(0, 2097151)));
        end
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_ord_limit(int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ORD_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_ord = v;
    endtask

    // Stimulus: directed cases, then random phases under several order limits.
    initial begin
        int phase_limit[4] = '{0, 15, 3, 10};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        free_total = '0;
        managed_total = '0;
        max_ord = TOP_ORDER;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_ALLOC, 0, 0);
        issue(OP_ALLOC, 0, 1);
        issue(OP_FREE, 0, 4);
        issue(OP_FREE, 64, 0);
        issue(OP_FREE, 1, 21'h100000);
        issue(OP_ALLOC, 20'hFFFFF, 21'h100000);
        issue(2'd3, 20'hFFFFF, 21'h1FFFFF);
        issue(OP_SPAN, 4096, 0);
        issue(OP_SPAN, 0, 64);
        issue(OP_SPAN, 20'hFFFF0, 100);
        issue(OP_SPAN, 4096, 4096);
        issue(OP_ALLOC, 0, 1024);
        issue(OP_ALLOC, 0, 3);
        issue(OP_ALLOC, 0, 1025);
        issue(OP_ALLOC, 0, 1);
        issue(OP_ALLOC, 0, 1);
        issue(OP_FREE, 4097, 2);
        issue(OP_FREE, 4096, 2048);
        free_live_block();
        free_live_block();
        free_live_block();
        free_live_block();
        issue(OP_FREE, 3, 1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_ord_limit(phase_limit[ph]);
            // With single-page blocks the order 0 stack overflows, then drains.
            if (phase_limit[ph] == 0) begin
                issue(OP_SPAN, 20000, 300);
                repeat (300) issue(OP_ALLOC, 0, 1);
                issue(OP_ALLOC, 0, 2);
            end
            repeat (320) random_request();
            wait_idle();
        end

        if (mismatches == 0)
            $display("** buddy_page_allocator: PASSED **");
        else
            $display("** buddy_page_allocator: FAILED **");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps.
    int send_burst;
    int send_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            op          <= '0;
            frame       <= '0;
            count_pages <= '0;
            send_burst  <= 0;
            send_gap    <= 0;
        end
        else if (!in_valid || in_ready) begin
            if (in_valid) void'(pending_requests.pop_front());
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_requests.size() != 0) begin
                request_t nxt;
                nxt = pending_requests[0];
                in_valid    <= 1'b1;
                op          <= nxt.op;
                frame       <= nxt.frame;
                count_pages <= nxt.count;
                if (send_burst <= 1) begin
                    send_burst <= $urandom_range(1, 40);
                    send_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
                else begin
                    send_burst <= send_burst - 1;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, free-running stretches and one long hold-off.
    int hold_left;
    int mode_left;
    bit eager;
    bit long_done;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
            eager     <= 1'b0;
            long_done <= 1'b0;
        end
        else if (!long_done && results_seen >= 400) begin
            long_done <= 1'b1;
            hold_left <= LONG_STALL;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(50, 300);
                eager     <= 1'($urandom_range(0, 1));
            end
            else begin
                mode_left <= mode_left - 1;
            end
            out_ready <= eager || ($urandom_range(0, 3) != 0);
        end
    end

    // Result monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            results_seen <= 0;
        end
        else if (out_valid && out_ready) begin
            outcome_t want;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result: frame %0d status %0d", alloc_frame, status);
            end
            else begin
                want = expected_results.pop_front();
                if (want.alloc_frame !== alloc_frame || want.status !== status
                    || want.free_pages !== free_pages
                    || want.managed_pages !== managed_pages) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"result %0d: expected frame %0d st %0d free %0d mgd %0d,",
                                  " got %0d %0d %0d %0d"},
                                 results_seen, want.alloc_frame, want.status, want.free_pages,
                                 want.managed_pages, alloc_frame, status, free_pages,
                                 managed_pages);
                end
            end
        end
    end

    // Watchdog: cycles in which no transaction moves on any channel.
    int quiet_cycles;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** buddy_page_allocator: FAILED **");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> filelist.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_ctrl.sv
design/bpa_dp.sv
design/buddy_page_allocator.sv
verif/tb.sv
